### hdl/swm_pkg.sv
// Shared constants and types for the sliding window median core.
package swm_pkg;

  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int TAG_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_BITS   = $clog2(WINDOW + 1);

  // One sorted window entry: sample value plus the arrival slot it came from.
  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [TAG_BITS-1:0]           tag;
  } swm_entry_t;

  // Flags a node hands to its neighbors.
  typedef struct packed {
    logic le;       // entry is valid and not greater than the new sample
    logic evicted;  // entry leaves the window on this transfer
  } swm_flags_t;

endpackage

### hdl/sliding_window_median_core.sv
// Top level of the running median filter: node chain, fill tracking and result register.
// result_valid is registered and rises in the cycle after a sample transfer.
// Throughput: one sample per cycle unless a held result stalls; each transfer shifts
// the whole node chain once, the evicted and the inserted entry both settling in that same cycle.
// Reset (rst, synchronous): window empty, arrival slot and fill count zero, no result held.
module sliding_window_median_core import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] median_value,
  output logic [FILL_BITS-1:0]          window_fill
);

  logic                 load;
  logic                 full;
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  logic [TAG_BITS-1:0]  wr_ptr;
  logic [TAG_BITS-1:0]  wr_ptr_next;
  logic [FILL_BITS-1:0] fill_half;
  logic [TAG_BITS-1:0]  median_idx;

  swm_entry_t entries     [WINDOW];
  swm_entry_t entries_nxt [WINDOW];
  swm_flags_t flags       [WINDOW];
  logic       evict_chain [WINDOW+1];

  swm_entry_t left_edge;
  swm_entry_t right_edge;

  assign sample_stall = result_valid & result_stall;
  assign load         = sample_valid & ~sample_stall;

  assign full        = (fill == FILL_BITS'(WINDOW));
  assign fill_next   = full ? fill : fill + FILL_BITS'(1);
  assign wr_ptr_next = (wr_ptr == TAG_BITS'(WINDOW - 1)) ? '0 : wr_ptr + TAG_BITS'(1);
  assign fill_half   = fill_next >> 1;
  assign median_idx  = fill_half[TAG_BITS-1:0];

  // Chain ends: the left edge always admits the new sample, the right edge is empty.
  always_comb begin
    left_edge       = '0;
    left_edge.valid = 1'b1;
    right_edge      = '0;
  end

  assign evict_chain[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_node
    swm_entry_t left_e;
    swm_entry_t right_e;
    logic       left_l;
    logic       right_l;

    if (i == 0) begin : g_first
      assign left_e = left_edge;
      assign left_l = 1'b1;
    end else begin : g_inner_l
      assign left_e = entries[i-1];
      assign left_l = flags[i-1].le;
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_e = right_edge;
      assign right_l = 1'b0;
    end else begin : g_inner_r
      assign right_e = entries[i+1];
      assign right_l = flags[i+1].le;
    end

    swm_node u_node (
      .clk           (clk),
      .rst           (rst),
      .load          (load),
      .full          (full),
      .sample        (sample),
      .wr_ptr        (wr_ptr),
      .evict_left    (evict_chain[i]),
      .evict_through (evict_chain[i+1]),
      .left_entry    (left_e),
      .left_le       (left_l),
      .right_entry   (right_e),
      .right_le      (right_l),
      .entry         (entries[i]),
      .flags         (flags[i]),
      .entry_next    (entries_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      wr_ptr       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        fill   <= fill_next;
        wr_ptr <= wr_ptr_next;
      end
      // Hold the result until its transfer; a new sample reloads it.
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median_value <= entries_nxt[median_idx].value;
      window_fill  <= fill_next;
    end
  end

  // Only the tail of the eviction chain is unused by a node.
  logic unused_evict;
  assign unused_evict = evict_chain[WINDOW];

endmodule

### hdl/swm_node.sv
// One node of the sorted chain: holds one window entry and shifts with its neighbors.
module swm_node import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [TAG_BITS-1:0]           wr_ptr,
  input  logic                          evict_left,
  output logic                          evict_through,
  input  swm_entry_t                    left_entry,
  input  logic                          left_le,
  input  swm_entry_t                    right_entry,
  input  logic                          right_le,
  output swm_entry_t                    entry,
  output swm_flags_t                    flags,
  output swm_entry_t                    entry_next
);

  swm_entry_t mid_entry;
  swm_entry_t lo_entry;
  logic       mid_le;
  logic       lo_le;
  logic       shift_left;

  always_comb begin
    flags.le      = entry.valid && !($signed(sample) < $signed(entry.value));
    flags.evicted = full && entry.valid && (entry.tag == wr_ptr);
  end

  assign evict_through = evict_left | flags.evicted;
  assign shift_left    = evict_left | flags.evicted;

  // Pull from the right once the evicted entry is at or left of this node.
  always_comb begin
    mid_entry = shift_left ? right_entry : entry;
    mid_le    = shift_left ? right_le    : flags.le;
    lo_entry  = evict_left ? entry       : left_entry;
    lo_le     = evict_left ? flags.le    : left_le;
  end

  always_comb begin
    priority if (mid_le) begin
      entry_next.value = mid_entry.value;
      entry_next.tag   = mid_entry.tag;
    end else if (lo_le) begin
      entry_next.value = sample;
      entry_next.tag   = wr_ptr;
    end else begin
      entry_next.value = lo_entry.value;
      entry_next.tag   = lo_entry.tag;
    end
    // Window grows by one slot per transfer until full.
    entry_next.valid = full ? entry.valid : (entry.valid | left_entry.valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry <= entry_next;
    end
  end

endmodule

### bench/tb_sliding_window_median_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the running median filter core.
module tb_sliding_window_median_core;
  import swm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t              median;
    logic [FILL_BITS-1:0] fill;
  } median_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  sample_t              median_value;
  logic [FILL_BITS-1:0] window_fill;

  sliding_window_median_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .median_value (median_value),
    .window_fill  (window_fill)
  );

  always #10 clk = ~clk;

  // Window model: arrival FIFO plus a sorted copy of the same samples.
  sample_t     win_fifo   [WINDOW];
  sample_t     win_sorted [WINDOW];
  int unsigned oldest_slot = 0;
  int unsigned win_count   = 0;

  sample_t        sample_q [$];
  median_result_t median_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        send_hold     = 1'b0;
  int unsigned errors        = 0;
  int unsigned transfers     = 0;
  int unsigned evictions     = 0;
  int unsigned results_seen  = 0;

  function automatic median_result_t window_insert(input sample_t s);
    median_result_t r;
    sample_t        gone;
    int unsigned    n;
    int unsigned    k;
    int unsigned    p;
    n = win_count;
    if (n == WINDOW) begin
      // Drop one sorted copy of the oldest sample, then reuse its FIFO slot.
      gone = win_fifo[oldest_slot];
      k = 0;
      while (k < n - 1 && win_sorted[k] != gone) k++;
      for (int unsigned j = k; j + 1 < n; j++) win_sorted[j] = win_sorted[j + 1];
      n--;
      win_fifo[oldest_slot] = s;
      oldest_slot = (oldest_slot + 1) % WINDOW;
      evictions++;
    end else begin
      win_fifo[n] = s;
    end
    p = 0;
    while (p < n && win_sorted[p] <= s) p++;
    for (int unsigned j = n; j > p; j--) win_sorted[j] = win_sorted[j - 1];
    win_sorted[p] = s;
    n++;
    win_count = n;
    r.median = win_sorted[n / 2];
    r.fill   = FILL_BITS'(n);
    return r;
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        median_q.push_back(window_insert(sample));
        transfers++;
      end
      // hold a stalled transfer, otherwise pick the next one or idle
      if (!(sample_valid && sample_stall)) begin
        if (sample_q.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          sample       <= sample_q.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    median_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result median %0d fill %0d", $time, median_value,
                   window_fill);
        end else begin
          want = median_q.pop_front();
          if (median_value !== want.median) begin
            errors++;
            $display("%0t: median_value expected %0d actual %0d", $time, want.median,
                     median_value);
          end
          if (window_fill !== want.fill) begin
            errors++;
            $display("%0t: window_fill expected %0d actual %0d", $time, want.fill,
                     window_fill);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  sample_t     last_sample = '0;
  sample_t     ramp        = '0;

  task automatic add_random(input int unsigned n);
    sample_t s;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2: s = sample_t'($urandom);
        3, 4:    s = sample_t'($signed($urandom_range(16)) - 8);
        5:       s = $urandom_range(1) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} + sample_t'($urandom_range(3))
                                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}} - sample_t'($urandom_range(3));
        6, 7:    s = last_sample;  // duplicates stress the equal-copy eviction
        8: begin
          ramp = ramp + sample_t'($urandom_range(1000));
          s = ramp;
        end
        default: begin
          ramp = ramp - sample_t'($urandom_range(1000));
          s = ramp;
        end
      endcase
      last_sample = s;
      sample_q.push_back(s);
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || sample_valid || median_q.size() > 0) @(negedge clk);
  endtask

  initial begin
    int unsigned spin;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, duplicates, ordered runs, then evictions of equal copies.
    sample_q.push_back({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    sample_q.push_back({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    sample_q.push_back('0);
    sample_q.push_back(-1);
    sample_q.push_back(1);
    repeat (3) sample_q.push_back(5);
    for (int i = 0; i < 5; i++) sample_q.push_back(sample_t'(i * 100 - 300));
    for (int i = 0; i < 5; i++) sample_q.push_back(sample_t'(400 - i * 200));
    repeat (4) sample_q.push_back({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    repeat (2) sample_q.push_back(5);

    send_idle_pct = 38;
    recv_idle_pct = 85;
    add_random(250);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 38;
    add_random(270);
    while (sample_q.size() > 130) @(negedge clk);
    // pause the sender until every outstanding result is back
    send_hold = 1'b1;
    while (sample_valid || median_q.size() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
    send_hold = 1'b0;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(260);
    while (sample_q.size() > 0 || sample_valid) @(negedge clk);
    spin = 0;
    while (median_q.size() > 0 && spin < 5000) begin
      @(negedge clk);
      spin++;
    end
    if (median_q.size() > 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, median_q.size());
    end
    repeat (4) @(posedge clk);

    $display("Sent %0d samples and checked %0d medians; %0d of them evicted an old sample.",
             transfers, results_seen, evictions);
    $display("Covered fill-up, full-window replacement, duplicates and both signed extremes.");
    if (errors == 0) begin
      $display("tb_sliding_window_median_core: PASS");
    end else begin
      $display("tb_sliding_window_median_core: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("tb_sliding_window_median_core: FAIL");
    $finish;
  end

endmodule

### files.f
hdl/swm_pkg.sv
hdl/swm_node.sv
hdl/sliding_window_median_core.sv
bench/tb_sliding_window_median_core.sv
